FILE: hdl/ssvf_pkg.sv
// Shared types and constants for the stereo state variable filter.
`timescale 1ns / 1ps

package ssvf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 32;
  localparam int STATE_W   = 40;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_COEF  = 6;

  // Configuration register indexes, also used to pick a gain for the multiplier.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A1        = 3'd0,
    CFG_A2        = 3'd1,
    CFG_A3        = 3'd2,
    CFG_MIX_INPUT = 3'd3,
    CFG_MIX_BAND  = 3'd4,
    CFG_MIX_LOW   = 3'd5
  } coef_e;

  // Operand of a product.
  typedef enum logic [2:0] {
    VAL_BAND,
    VAL_V3,
    VAL_X,
    VAL_V1,
    VAL_V2
  } val_sel_e;

  // What the accumulate stage does with a finished product.
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LD_V1,
    ACC_ADD_V1,
    ACC_LD_V2,
    ACC_ADD_V2,
    ACC_LD_Y,
    ACC_ADD_Y
  } acc_op_e;

  typedef struct packed {
    logic     in_load;
    logic     issue;
    logic     ch;
    coef_e    gain;
    val_sel_e val;
    acc_op_e  op;
    logic     fin_v;
    logic     fin_state;
    logic     y_wr;
    logic     out_load;
  } ssvf_cmd_t;

endpackage

FILE: hdl/ssvf_in_if.sv
// Input channel carrying one stereo sample pair per transfer.
`timescale 1ns / 1ps

interface ssvf_in_if import ssvf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

FILE: hdl/ssvf_out_if.sv
// Output channel carrying one filtered stereo pair per transfer.
`timescale 1ns / 1ps

interface ssvf_out_if import ssvf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

FILE: hdl/ssvf_datapath.sv
// Filter datapath: coefficients, integrator state, shared multiplier and accumulators.
`timescale 1ns / 1ps

module ssvf_datapath import ssvf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssvf_cmd_t                  cmd_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [COEF_W-1:0]          cfg_data_i,
  input  logic signed [SAMPLE_W-1:0] left_sample_i,
  input  logic signed [SAMPLE_W-1:0] right_sample_i,
  output logic signed [SAMPLE_W-1:0] left_out_o,
  output logic signed [SAMPLE_W-1:0] right_out_o
);

  localparam int FRAC   = 24;
  localparam int VAL_W  = STATE_W + 1;
  localparam int PROD_W = 2 * COEF_W;
  localparam int BH_W   = VAL_W - COEF_W;
  localparam int HI_W   = COEF_W + BH_W;
  localparam int LO_W   = PROD_W + 1 - FRAC;
  localparam int MAG_W  = 50;
  localparam int ACC_W  = 52;

  localparam logic [PROD_W:0] RND = (PROD_W + 1)'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] ST_MAX = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ST_MIN = -(ACC_W'(1) <<< (STATE_W - 1));
  localparam logic signed [ACC_W-1:0] SM_MAX = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SM_MIN = -(ACC_W'(1) <<< (SAMPLE_W - 1));

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v > ST_MAX) r = ST_MAX[STATE_W-1:0];
    else if (v < ST_MIN) r = ST_MIN[STATE_W-1:0];
    else r = v[STATE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SM_MAX) r = SM_MAX[SAMPLE_W-1:0];
    else if (v < SM_MIN) r = SM_MIN[SAMPLE_W-1:0];
    else r = v[SAMPLE_W-1:0];
    return r;
  endfunction

  logic signed [COEF_W-1:0]   coef_q [NUM_COEF];
  logic signed [SAMPLE_W-1:0] x_q    [2];
  logic signed [STATE_W-1:0]  band_q [2];
  logic signed [STATE_W-1:0]  low_q  [2];
  logic signed [STATE_W-1:0]  v1_q, v2_q;
  logic signed [SAMPLE_W-1:0] y_q    [2];
  logic signed [SAMPLE_W-1:0] left_out_q, right_out_q;

  logic [COEF_W-1:0] a_mag_q;
  logic [VAL_W-1:0]  b_mag_q;
  logic              neg_q, neg_hi_q, mag_neg_q;
  logic [PROD_W-1:0] prod_q;
  logic [LO_W-1:0]   lo_q;
  logic [MAG_W-1:0]  mag_q;
  acc_op_e           op_ld_q, op_lo_q, op_hi_q, op_sum_q;
  logic              ch_ld_q, ch_lo_q, ch_hi_q, ch_sum_q;

  logic signed [ACC_W-1:0] acc_v1_q, acc_v2_q, acc_y_q;

  logic signed [COEF_W-1:0] gain;
  logic signed [VAL_W-1:0]  v3;
  logic signed [VAL_W-1:0]  sel_val;
  logic [COEF_W-1:0]        a_abs;
  logic [VAL_W-1:0]         b_abs;
  logic [COEF_W-1:0]        mul_b;
  logic signed [ACC_W-1:0]  acc_base, acc_term, acc_sum;
  logic signed [ACC_W-1:0]  band_upd, low_upd;

  // Operand selection for a product about to be issued.
  always_comb begin
    gain = coef_q[cmd_i.gain];
    v3   = VAL_W'(x_q[cmd_i.ch]) - VAL_W'(low_q[cmd_i.ch]);
    case (cmd_i.val)
      VAL_BAND: sel_val = VAL_W'(band_q[cmd_i.ch]);
      VAL_V3:   sel_val = v3;
      VAL_X:    sel_val = VAL_W'(x_q[cmd_i.ch]);
      VAL_V1:   sel_val = VAL_W'(v1_q);
      VAL_V2:   sel_val = VAL_W'(v2_q);
      default:  sel_val = '0;
    endcase
    a_abs = gain[COEF_W-1] ? COEF_W'(-gain) : COEF_W'(gain);
    b_abs = sel_val[VAL_W-1] ? VAL_W'(-sel_val) : VAL_W'(sel_val);
  end

  // The second multiplier pass takes the upper bits of the operand magnitude.
  assign mul_b = (op_lo_q != ACC_NONE) ? COEF_W'(b_mag_q[VAL_W-1:COEF_W])
                                       : b_mag_q[COEF_W-1:0];

  // Rounded products are kept as magnitudes; the sign picks add or subtract here.
  always_comb begin
    case (op_sum_q)
      ACC_ADD_V1: acc_base = acc_v1_q;
      ACC_LD_V2:  acc_base = ACC_W'(low_q[ch_sum_q]);
      ACC_ADD_V2: acc_base = acc_v2_q;
      ACC_ADD_Y:  acc_base = acc_y_q;
      default:    acc_base = '0;
    endcase
    acc_term = signed'(ACC_W'(mag_q));
    acc_sum  = mag_neg_q ? (acc_base - acc_term) : (acc_base + acc_term);
    band_upd = (ACC_W'(v1_q) <<< 1) - ACC_W'(band_q[cmd_i.ch]);
    low_upd  = (ACC_W'(v2_q) <<< 1) - ACC_W'(low_q[cmd_i.ch]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i] <= (i == int'(CFG_MIX_INPUT)) ? (COEF_W'(1) << FRAC) : '0;
      end
      for (int c = 0; c < 2; c++) begin
        band_q[c] <= '0;
        low_q[c]  <= '0;
      end
      op_ld_q  <= ACC_NONE;
      op_lo_q  <= ACC_NONE;
      op_hi_q  <= ACC_NONE;
      op_sum_q <= ACC_NONE;
    end else begin
      if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_COEF))) begin
        coef_q[cfg_idx_i] <= signed'(cfg_data_i);
      end
      if (cmd_i.fin_state) begin
        band_q[cmd_i.ch] <= sat_state(band_upd);
        low_q[cmd_i.ch]  <= sat_state(low_upd);
      end
      op_ld_q  <= cmd_i.issue ? cmd_i.op : ACC_NONE;
      op_lo_q  <= op_ld_q;
      op_hi_q  <= op_lo_q;
      op_sum_q <= op_hi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      x_q[0] <= left_sample_i;
      x_q[1] <= right_sample_i;
    end
    if (cmd_i.issue) begin
      a_mag_q <= a_abs;
      b_mag_q <= b_abs;
      neg_q   <= gain[COEF_W-1] ^ sel_val[VAL_W-1];
      ch_ld_q <= cmd_i.ch;
    end
    if ((op_ld_q != ACC_NONE) || (op_lo_q != ACC_NONE)) begin
      prod_q <= a_mag_q * mul_b;
    end
    ch_lo_q  <= ch_ld_q;
    ch_hi_q  <= ch_lo_q;
    ch_sum_q <= ch_hi_q;
    if (op_lo_q != ACC_NONE) begin
      lo_q     <= LO_W'(((PROD_W + 1)'(prod_q) + RND) >> FRAC);
      neg_hi_q <= neg_q;
    end
    if (op_hi_q != ACC_NONE) begin
      mag_q     <= (MAG_W'(prod_q[HI_W-1:0]) << (COEF_W - FRAC)) + MAG_W'(lo_q);
      mag_neg_q <= neg_hi_q;
    end
    case (op_sum_q)
      ACC_LD_V1, ACC_ADD_V1: acc_v1_q <= acc_sum;
      ACC_LD_V2, ACC_ADD_V2: acc_v2_q <= acc_sum;
      ACC_LD_Y, ACC_ADD_Y:   acc_y_q  <= acc_sum;
      default: ;
    endcase
    if (cmd_i.fin_v) begin
      v1_q <= sat_state(acc_v1_q);
      v2_q <= sat_state(acc_v2_q);
    end
    if (cmd_i.y_wr) begin
      y_q[cmd_i.ch] <= sat_sample(acc_y_q);
    end
    if (cmd_i.out_load) begin
      left_out_q  <= y_q[0];
      right_out_q <= y_q[1];
    end
  end

  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

  // The multiplier reads the operand registers during both passes after an issue.
  a_issue_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_ld_q != ACC_NONE) |-> !cmd_i.issue)
    else $error("product issued while the previous one is in its first pass");

  // A product reaches the accumulate stage through op_ld_q, op_lo_q, op_hi_q and op_sum_q in turn.
  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> ##4 (op_sum_q != ACC_NONE))
    else $error("issued product did not reach the accumulate stage");

endmodule

FILE: hdl/ssvf_ctrl.sv
// Sequencer that steps the datapath through both channels of one sample pair.
`timescale 1ns / 1ps

module ssvf_ctrl import ssvf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ssvf_cmd_t  cmd_o
);

  localparam int          STEP_W    = 6;
  localparam int          CH_OFFSET = 16;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CH_OFFSET + 19);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic              slot_free;
  logic [STEP_W-1:0] rel;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Each channel runs the same step pattern; the right one starts CH_OFFSET steps late
  // and the two patterns never use the issue slot or a channel-indexed write together.
  always_comb begin
    cmd_o          = '0;
    cmd_o.gain     = CFG_A1;
    cmd_o.val      = VAL_BAND;
    cmd_o.op       = ACC_NONE;
    cmd_o.in_load  = in_valid_i && (state_q == ST_IDLE);
    cmd_o.out_load = (state_q == ST_HOLD) && slot_free;
    rel            = '0;
    if (state_q == ST_RUN) begin
      for (int c = 0; c < 2; c++) begin
        if (step_q >= STEP_W'(c * CH_OFFSET)) begin
          rel = step_q - STEP_W'(c * CH_OFFSET);
          case (rel)
            6'd0: begin
              cmd_o.issue = 1'b1; cmd_o.ch = 1'(c);
              cmd_o.gain = CFG_A1; cmd_o.val = VAL_BAND; cmd_o.op = ACC_LD_V1;
            end
            6'd2: begin
              cmd_o.issue = 1'b1; cmd_o.ch = 1'(c);
              cmd_o.gain = CFG_A2; cmd_o.val = VAL_V3; cmd_o.op = ACC_ADD_V1;
            end
            6'd4: begin
              cmd_o.issue = 1'b1; cmd_o.ch = 1'(c);
              cmd_o.gain = CFG_A2; cmd_o.val = VAL_BAND; cmd_o.op = ACC_LD_V2;
            end
            6'd6: begin
              cmd_o.issue = 1'b1; cmd_o.ch = 1'(c);
              cmd_o.gain = CFG_A3; cmd_o.val = VAL_V3; cmd_o.op = ACC_ADD_V2;
            end
            6'd8: begin
              cmd_o.issue = 1'b1; cmd_o.ch = 1'(c);
              cmd_o.gain = CFG_MIX_INPUT; cmd_o.val = VAL_X; cmd_o.op = ACC_LD_Y;
            end
            6'd11: begin
              cmd_o.fin_v = 1'b1;
            end
            6'd12: begin
              cmd_o.issue = 1'b1; cmd_o.ch = 1'(c); cmd_o.fin_state = 1'b1;
              cmd_o.gain = CFG_MIX_BAND; cmd_o.val = VAL_V1; cmd_o.op = ACC_ADD_Y;
            end
            6'd14: begin
              cmd_o.issue = 1'b1; cmd_o.ch = 1'(c);
              cmd_o.gain = CFG_MIX_LOW; cmd_o.val = VAL_V2; cmd_o.op = ACC_ADD_Y;
            end
            6'd19: begin
              cmd_o.y_wr = 1'b1; cmd_o.ch = 1'(c);
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_RUN;
            step_q  <= '0;
          end
        end
        ST_RUN: begin
          if (step_q == LAST_STEP) begin
            state_q <= ST_HOLD;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while holding an untaken pair");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_RUN) && (step_q == '0))
    else $error("accepted pair did not start the sequence at step zero");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= LAST_STEP))
    else $error("sequence step ran past the last step");

endmodule

FILE: hdl/stereo_state_variable_filter_unit.sv
// Top level of the stereo state variable filter: sequencer, datapath and channel hookup.
`timescale 1ns / 1ps

// Runs a trapezoidal state variable filter on the left and right sample of each
// transfer, with one shared set of six Q8.24 gains written through the config port;
// the user writes them only while the unit is idle, which the unit does not enforce.
// A pair passes the accepting cycle, 36 sequencer steps and a move into the output
// register, which waits while that register holds an untaken pair, before a new pair
// is taken. The single 32x32 multiplier sets the sequence length, making two passes
// for each of the fourteen products of a pair. The output register holds a finished
// pair while the unit takes and filters the next one.

module stereo_state_variable_filter_unit import ssvf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ssvf_in_if.sink              sample_i,
  ssvf_out_if.source           filt_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  ssvf_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;

  ssvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (filt_o.ready),
    .cmd_o       (cmd)
  );

  ssvf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .left_sample_i  (sample_i.left_sample),
    .right_sample_i (sample_i.right_sample),
    .left_out_o     (filt_o.left_out),
    .right_out_o    (filt_o.right_out)
  );

  assign sample_i.ready = in_ready;
  assign filt_o.valid   = out_valid;

endmodule
